// ===== hw/rtl/lz_hash_chain_approx_match_parser_top_assert.svh =====
// ----------------------------------------------------------------------------
// LZ parser assertion macros
// Shared property shapes for the parser's concurrent checks.
// ----------------------------------------------------------------------------
`ifndef LZ_HASH_CHAIN_APPROX_MATCH_PARSER_TOP_ASSERT_SVH
`define LZ_HASH_CHAIN_APPROX_MATCH_PARSER_TOP_ASSERT_SVH

// same-cycle implication
`define LZHC_ASSERT_IMP(lbl, ck, rn, a, c, msg) \
  lbl: assert property (@(posedge ck) disable iff (!(rn)) (a) |-> (c)) else $error(msg);

// next-cycle implication
`define LZHC_ASSERT_NXT(lbl, ck, rn, a, c, msg) \
  lbl: assert property (@(posedge ck) disable iff (!(rn)) (a) |=> (c)) else $error(msg);

`endif

// ===== hw/rtl/lzhc_pkg.sv =====
// ----------------------------------------------------------------------------
// LZ parser package
// Item types, result codes, register indexes and the 4-byte hash.
// ----------------------------------------------------------------------------
package lzhc_pkg;

  localparam int MIN_LEN     = 4;
  localparam int MAX_PATCHES = 3;
  localparam int CFG_IW      = 2;
  localparam int CFG_DW      = 9;

  localparam logic [CFG_IW-1:0] CFG_APPROX = 2'd0;
  localparam logic [CFG_IW-1:0] CFG_DEPTH  = 2'd1;
  localparam logic [CFG_IW-1:0] CFG_NICE   = 2'd2;

  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_FIND = 1'b1;

  localparam logic [2:0] K_LOADED  = 3'd0;
  localparam logic [2:0] K_REFUSED = 3'd1;
  localparam logic [2:0] K_NEED    = 3'd2;
  localparam logic [2:0] K_DONE    = 3'd3;
  localparam logic [2:0] K_LIT     = 3'd4;
  localparam logic [2:0] K_EXACT   = 3'd5;
  localparam logic [2:0] K_APPROX  = 3'd6;

  typedef struct packed {
    logic       req_type;
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  result_kind;
    logic [7:0]  literal_value;
    logic [8:0]  copy_len;
    logic [16:0] match_distance;
    logic [1:0]  edit_count;
    logic [8:0]  edit_offset_0;
    logic [8:0]  edit_offset_1;
    logic [8:0]  edit_offset_2;
    logic [7:0]  edit_value_0;
    logic [7:0]  edit_value_1;
    logic [7:0]  edit_value_2;
  } out_item_t;

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_H0, S_H1, S_H2, S_H3, S_H4, S_CAND, S_CMP, S_EVAL,
    S_LINK0, S_LINK1, S_POST, S_SKIP, S_LIT, S_FIN
  } state_t;

  function automatic logic [19:0] hash4(input logic [7:0] b0, input logic [7:0] b1,
                                        input logic [7:0] b2, input logic [7:0] b3);
    hash4 = (20'(b0) << 11) ^ (20'(b1) << 5) ^ (20'(b2) << 1) ^ (20'(b3) >> 2);
  endfunction

endpackage

// ===== hw/rtl/lzhc_stream_if.sv =====
// ----------------------------------------------------------------------------
// LZ parser stream interface
// Valid/ready channel carrying one item of type T.
// ----------------------------------------------------------------------------
interface lzhc_stream_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== hw/rtl/lzhc_ring.sv =====
// ----------------------------------------------------------------------------
// LZ parser data ring
// Byte memory, one write port and two registered read ports.
// ----------------------------------------------------------------------------
module lzhc_ring #(
  parameter int AW = 17
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [7:0]    wdata,
  input  logic [AW-1:0] raddr_a,
  input  logic [AW-1:0] raddr_b,
  output logic [7:0]    qa,
  output logic [7:0]    qb
);

  logic [7:0] mem [1<<AW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    qa <= mem[raddr_a];
    qb <= mem[raddr_b];
  end

endmodule

// ===== hw/rtl/lz_hash_chain_approx_match_parser_top.sv =====
// ----------------------------------------------------------------------------
// LZ hash-chain parser with approximate matches
// Greedy LZ77 token coder over a byte ring with a hash-chain match finder.
// ----------------------------------------------------------------------------
// One item is handled at a time; in_if.ready is high only while idle. After
// reset the bucket table is swept clear before the first item is taken. A
// load writes its byte to the ring and then offers its result. A find first
// inserts its own hash when four bytes are at hand, then for each chain
// candidate compares bytes, one byte pair a cycle from the dual-port byte
// ring, then inserts the hash of each position skipped over after a match.
`include "lz_hash_chain_approx_match_parser_top_assert.svh"

module lz_hash_chain_approx_match_parser_top
  import lzhc_pkg::*;
#(
  parameter int WINDOW_LOG2     = 16,
  parameter int HASH_LOG2       = 16,
  parameter int MAX_CHAIN_DEPTH = 32,
  parameter int MAX_MATCH_LEN   = 273,
  parameter int RING_LOG2       = 17
) (
  input  logic              clk,
  input  logic              rst_n,
  lzhc_stream_if.sink       in_if,
  lzhc_stream_if.source     out_if,
  input  logic              cfg_we,
  input  logic [CFG_IW-1:0] cfg_index,
  input  logic [CFG_DW-1:0] cfg_data
);

  localparam int W   = WINDOW_LOG2;
  localparam int H   = HASH_LOG2;
  localparam int R   = RING_LOG2;
  localparam int LW  = $clog2(MAX_MATCH_LEN + 1);
  localparam int DW  = W + 1;
  localparam int CDL = (MAX_CHAIN_DEPTH > 63) ? 63 : MAX_CHAIN_DEPTH;
  localparam logic [5:0]  CD_CAP   = 6'(CDL);
  localparam logic [31:0] WS32     = 32'(1 << W);
  localparam logic [31:0] ROOM     = 32'((1 << R) - (1 << W));
  localparam logic [31:0] NEED_MIN = 32'(MAX_MATCH_LEN + 3);
  localparam logic [31:0] MAXL32   = 32'(MAX_MATCH_LEN);
  localparam logic [LW-1:0] MINL   = LW'(MIN_LEN);

  state_t state_r, state_nxt;

  logic [H-1:0]  clr_r, clr_nxt;
  logic [31:0]   pos_r, pos_nxt, loaded_r, loaded_nxt;
  logic          ended_r, ended_nxt;
  logic          approx_r;
  logic [5:0]    depth_r;
  logic [8:0]    nice_r;
  logic [LW-1:0] maxlen_r, maxlen_nxt;
  logic [31:0]   ip_r, ip_nxt;
  logic          main_r, main_nxt;
  logic [7:0]    bq_r [4];
  logic [7:0]    bq_nxt [4];
  logic [H-1:0]  hq_r, hq_nxt;
  logic [W-1:0]  cur_r, cur_nxt;
  logic          ok_r, ok_nxt;
  logic [5:0]    d_r, d_nxt;
  logic [31:0]   ref_r, ref_nxt;
  logic [DW-1:0] dist_r, dist_nxt;
  logic [LW-1:0] ja_r, ja_nxt, jd_r, jd_nxt, xl_r, xl_nxt, len_r, len_nxt;
  logic          pv_r, pv_nxt, xrun_r, xrun_nxt;
  logic [1:0]    ed_r, ed_nxt;
  logic [LW-1:0] eo_r [MAX_PATCHES];
  logic [LW-1:0] eo_nxt [MAX_PATCHES];
  logic [7:0]    ev_r [MAX_PATCHES];
  logic [7:0]    ev_nxt [MAX_PATCHES];
  logic [LW-1:0] bl_r, bl_nxt;
  logic [DW-1:0] bd_r, bd_nxt;
  logic [1:0]    be_r, be_nxt;
  logic [LW-1:0] bo_r [MAX_PATCHES];
  logic [LW-1:0] bo_nxt [MAX_PATCHES];
  logic [7:0]    bv_r [MAX_PATCHES];
  logic [7:0]    bv_nxt [MAX_PATCHES];
  logic [LW-1:0] sj_r, sj_nxt;
  out_item_t     res_r, res_nxt, od_r, od_nxt;
  logic          ov_r, ov_nxt;

  // memory ports
  logic          ring_we;
  logic [R-1:0]  ring_wa, ra_a, ra_b;
  logic [7:0]    ring_wd, qa, qb;
  logic          head_we;
  logic [H-1:0]  head_wa, head_ra;
  logic [W:0]    head_wd, head_q;
  logic          link_we;
  logic [W-1:0]  link_wa, link_ra;
  logic [W:0]    link_wd, link_q;

  logic [W:0]    head_mem [1<<H];
  logic [W:0]    link_mem [1<<W];

  // helper values
  logic [31:0]   span, pa, pb, skip_p, ref_c;
  logic [19:0]   hval;
  logic          eq, done, hash_pos, hash_skip;
  logic          x_upd, brk, a_ok;
  logic [LW-1:0] bl1;
  logic [DW-1:0] bd1;
  logic [LW+1:0] lenw, xlw, e2;
  logic [5:0]    lim;

  lzhc_ring #(.AW(R)) u_ring (
    .clk     (clk),
    .we      (ring_we),
    .waddr   (ring_wa),
    .wdata   (ring_wd),
    .raddr_a (ra_a),
    .raddr_b (ra_b),
    .qa      (qa),
    .qb      (qb)
  );

  always_ff @(posedge clk) begin
    if (head_we) begin
      head_mem[head_wa] <= head_wd;
    end
    head_q <= head_mem[head_ra];
    if (link_we) begin
      link_mem[link_wa] <= link_wd;
    end
    link_q <= link_mem[link_ra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      approx_r <= 1'b1;
      depth_r  <= 6'd32;
      nice_r   <= 9'd64;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_APPROX: approx_r <= cfg_data[0];
        CFG_DEPTH:  depth_r  <= cfg_data[5:0];
        CFG_NICE:   nice_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_CLR;
      clr_r    <= '0;
      pos_r    <= '0;
      loaded_r <= '0;
      ended_r  <= 1'b0;
      ov_r     <= 1'b0;
      pv_r     <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      clr_r    <= clr_nxt;
      pos_r    <= pos_nxt;
      loaded_r <= loaded_nxt;
      ended_r  <= ended_nxt;
      ov_r     <= ov_nxt;
      pv_r     <= pv_nxt;
    end
  end

  always_ff @(posedge clk) begin
    maxlen_r <= maxlen_nxt;
    ip_r     <= ip_nxt;
    main_r   <= main_nxt;
    bq_r     <= bq_nxt;
    hq_r     <= hq_nxt;
    cur_r    <= cur_nxt;
    ok_r     <= ok_nxt;
    d_r      <= d_nxt;
    ref_r    <= ref_nxt;
    dist_r   <= dist_nxt;
    ja_r     <= ja_nxt;
    jd_r     <= jd_nxt;
    xl_r     <= xl_nxt;
    xrun_r   <= xrun_nxt;
    len_r    <= len_nxt;
    ed_r     <= ed_nxt;
    eo_r     <= eo_nxt;
    ev_r     <= ev_nxt;
    bl_r     <= bl_nxt;
    bd_r     <= bd_nxt;
    be_r     <= be_nxt;
    bo_r     <= bo_nxt;
    bv_r     <= bv_nxt;
    sj_r     <= sj_nxt;
    res_r    <= res_nxt;
    od_r     <= od_nxt;
  end

  assign in_if.ready  = (state_r == S_IDLE);
  assign out_if.valid = ov_r;
  assign out_if.data  = od_r;

  always_comb begin
    span      = loaded_r - pos_r;
    skip_p    = pos_r + 32'(sj_r);
    hash_pos  = !ended_r || ({1'b0, pos_r} + 33'd4 <= {1'b0, loaded_r});
    hash_skip = !ended_r || ({1'b0, skip_p} + 33'd4 <= {1'b0, loaded_r});
    hval      = hash4(bq_r[0], bq_r[1], bq_r[2], bq_r[3]);
    lim       = (depth_r > CD_CAP) ? CD_CAP : depth_r;
    ref_c     = {pos_r[31:W], cur_r};
    pa        = ref_r + 32'(ja_r);
    pb        = pos_r + 32'(ja_r);
    eq        = (qa == qb);
    done      = 1'b0;

    x_upd = (xl_r >= MINL) && (xl_r > bl_r);
    bl1   = x_upd ? xl_r : bl_r;
    bd1   = x_upd ? dist_r : bd_r;
    brk   = (bl1 >= MINL) && (xl_r == bl1) && (bd1 == dist_r) &&
            (32'(xl_r) >= 32'(nice_r));
    lenw  = (LW+2)'(len_r);
    xlw   = (LW+2)'(xl_r);
    e2    = (LW+2)'({ed_r, 1'b0});
    a_ok  = (ed_r != 2'd0) && (len_r >= MINL) && (lenw > e2 + (LW+2)'(3)) &&
            ((xl_r < MINL) || (lenw > xlw + e2)) && (len_r > bl1);

    state_nxt  = state_r;
    clr_nxt    = clr_r;
    pos_nxt    = pos_r;
    loaded_nxt = loaded_r;
    ended_nxt  = ended_r;
    maxlen_nxt = maxlen_r;
    ip_nxt     = ip_r;
    main_nxt   = main_r;
    bq_nxt     = bq_r;
    hq_nxt     = hq_r;
    cur_nxt    = cur_r;
    ok_nxt     = ok_r;
    d_nxt      = d_r;
    ref_nxt    = ref_r;
    dist_nxt   = dist_r;
    ja_nxt     = ja_r;
    jd_nxt     = jd_r;
    pv_nxt     = 1'b0;
    xl_nxt     = xl_r;
    xrun_nxt   = xrun_r;
    len_nxt    = len_r;
    ed_nxt     = ed_r;
    eo_nxt     = eo_r;
    ev_nxt     = ev_r;
    bl_nxt     = bl_r;
    bd_nxt     = bd_r;
    be_nxt     = be_r;
    bo_nxt     = bo_r;
    bv_nxt     = bv_r;
    sj_nxt     = sj_r;
    res_nxt    = res_r;
    od_nxt     = od_r;
    ov_nxt     = ov_r && !out_if.ready;

    ring_we = 1'b0;
    ring_wa = loaded_r[R-1:0];
    ring_wd = in_if.data.data_byte;
    ra_a    = pa[R-1:0];
    ra_b    = pb[R-1:0];
    head_we = 1'b0;
    head_wa = hq_r;
    head_wd = {1'b1, ip_r[W-1:0]};
    head_ra = hval[H-1:0];
    link_we = 1'b0;
    link_wa = ip_r[W-1:0];
    link_wd = head_q;
    link_ra = cur_r;

    case (state_r)
      S_CLR: begin
        head_we = 1'b1;
        head_wa = clr_r;
        head_wd = '0;
        clr_nxt = clr_r + 1'b1;
        if (&clr_r) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_if.valid) begin
          res_nxt   = '0;
          state_nxt = S_FIN;
          if (in_if.data.req_type == REQ_LOAD) begin
            if (ended_r || (&loaded_r) || (span >= ROOM)) begin
              res_nxt.result_kind = K_REFUSED;
            end else begin
              ring_we    = 1'b1;
              loaded_nxt = loaded_r + 32'd1;
              if (in_if.data.last_byte) begin
                ended_nxt = 1'b1;
              end
              res_nxt.result_kind = K_LOADED;
            end
          end else if (ended_r && (pos_r >= loaded_r)) begin
            res_nxt.result_kind = K_DONE;
          end else if (!ended_r && (span < NEED_MIN)) begin
            res_nxt.result_kind = K_NEED;
          end else begin
            maxlen_nxt = (ended_r && (span < MAXL32)) ? span[LW-1:0] : LW'(MAX_MATCH_LEN);
            bl_nxt     = '0;
            bd_nxt     = '0;
            be_nxt     = '0;
            ip_nxt     = pos_r;
            main_nxt   = 1'b1;
            state_nxt  = hash_pos ? S_H0 : S_POST;
          end
        end
      end
      S_H0: begin
        ra_a      = ip_r[R-1:0];
        ra_b      = R'(ip_r + 32'd1);
        state_nxt = S_H1;
      end
      S_H1: begin
        ra_a      = R'(ip_r + 32'd2);
        ra_b      = R'(ip_r + 32'd3);
        bq_nxt[0] = qa;
        bq_nxt[1] = qb;
        state_nxt = S_H2;
      end
      S_H2: begin
        bq_nxt[2] = qa;
        bq_nxt[3] = qb;
        state_nxt = S_H3;
      end
      S_H3: begin
        hq_nxt    = hval[H-1:0];
        state_nxt = S_H4;
      end
      S_H4: begin
        head_we = 1'b1;
        link_we = 1'b1;
        if (main_r) begin
          cur_nxt   = ip_r[W-1:0];
          ok_nxt    = 1'b1;
          d_nxt     = '0;
          state_nxt = S_CAND;
        end else begin
          sj_nxt    = sj_r + 1'b1;
          state_nxt = S_SKIP;
        end
      end
      S_CAND: begin
        if ((d_r < lim) && ok_r) begin
          ja_nxt   = '0;
          xl_nxt   = '0;
          xrun_nxt = 1'b1;
          len_nxt  = '0;
          ed_nxt   = '0;
          if (ref_c >= pos_r) begin
            ref_nxt   = ref_c - WS32;
            dist_nxt  = DW'(pos_r - (ref_c - WS32));
            state_nxt = (pos_r >= WS32) ? S_CMP : S_LINK0;
          end else begin
            ref_nxt   = ref_c;
            dist_nxt  = DW'(pos_r - ref_c);
            state_nxt = S_CMP;
          end
        end else begin
          state_nxt = S_POST;
        end
      end
      S_CMP: begin
        if (pv_r) begin
          if (xrun_r) begin
            if (eq) begin
              xl_nxt = jd_r + 1'b1;
            end else begin
              xrun_nxt = 1'b0;
            end
          end
          if (!eq) begin
            if (!approx_r) begin
              done = 1'b1;
            end else if (ed_r == 2'(MAX_PATCHES)) begin
              done = 1'b1;
            end else begin
              eo_nxt[ed_r] = jd_r;
              ev_nxt[ed_r] = qb;
              ed_nxt       = ed_r + 1'b1;
              len_nxt      = jd_r + 1'b1;
            end
          end else begin
            len_nxt = jd_r + 1'b1;
          end
          if (jd_r + 1'b1 == maxlen_r) begin
            done = 1'b1;
          end
        end
        if (done) begin
          state_nxt = S_EVAL;
        end else if (ja_r < maxlen_r) begin
          ja_nxt = ja_r + 1'b1;
          jd_nxt = ja_r;
          pv_nxt = 1'b1;
        end
      end
      S_EVAL: begin
        bl_nxt = bl1;
        bd_nxt = bd1;
        if (x_upd) begin
          be_nxt = '0;
        end
        if (!approx_r) begin
          state_nxt = brk ? S_POST : S_LINK0;
        end else begin
          if (a_ok) begin
            bl_nxt = len_r;
            bd_nxt = dist_r;
            be_nxt = ed_r;
            bo_nxt = eo_r;
            bv_nxt = ev_r;
          end
          state_nxt = S_LINK0;
        end
      end
      S_LINK0: begin
        state_nxt = S_LINK1;
      end
      S_LINK1: begin
        cur_nxt   = link_q[W-1:0];
        ok_nxt    = link_q[W];
        d_nxt     = d_r + 1'b1;
        state_nxt = S_CAND;
      end
      S_POST: begin
        if (bl_r >= MINL) begin
          sj_nxt    = LW'(1);
          state_nxt = S_SKIP;
        end else begin
          ra_a      = pos_r[R-1:0];
          state_nxt = S_LIT;
        end
      end
      S_SKIP: begin
        if ((sj_r < bl_r) && hash_skip) begin
          ip_nxt    = skip_p;
          main_nxt  = 1'b0;
          state_nxt = S_H0;
        end else begin
          res_nxt                = '0;
          res_nxt.result_kind    = (be_r != 2'd0) ? K_APPROX : K_EXACT;
          res_nxt.copy_len       = 9'(bl_r);
          res_nxt.match_distance = 17'(bd_r);
          res_nxt.edit_count     = be_r;
          if (be_r > 2'd0) begin
            res_nxt.edit_offset_0 = 9'(bo_r[0]);
            res_nxt.edit_value_0  = bv_r[0];
          end
          if (be_r > 2'd1) begin
            res_nxt.edit_offset_1 = 9'(bo_r[1]);
            res_nxt.edit_value_1  = bv_r[1];
          end
          if (be_r > 2'd2) begin
            res_nxt.edit_offset_2 = 9'(bo_r[2]);
            res_nxt.edit_value_2  = bv_r[2];
          end
          pos_nxt   = pos_r + 32'(bl_r);
          state_nxt = S_FIN;
        end
      end
      S_LIT: begin
        res_nxt               = '0;
        res_nxt.result_kind   = K_LIT;
        res_nxt.literal_value = qa;
        pos_nxt               = pos_r + 32'd1;
        state_nxt             = S_FIN;
      end
      S_FIN: begin
        if (!ov_r || out_if.ready) begin
          ov_nxt    = 1'b1;
          od_nxt    = res_r;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  `LZHC_ASSERT_NXT(a_busy_after_accept, clk, rst_n, in_if.valid && in_if.ready, !in_if.ready, "block ready right after taking an item")
  `LZHC_ASSERT_IMP(a_pos_le_loaded, clk, rst_n, 1'b1, pos_r <= loaded_r, "parse position passed loaded count")
  `LZHC_ASSERT_IMP(a_match_len_min, clk, rst_n, out_if.valid && (out_if.data.result_kind == K_EXACT || out_if.data.result_kind == K_APPROX), out_if.data.copy_len >= 9'd4, "match token shorter than minimum")

endmodule
